/* hdl/rwf_pkg.sv */
package rwf_pkg;

	localparam int WIDTH  = 320;
	localparam int HEIGHT = 240;

	localparam int COL_W = $clog2(WIDTH);
	localparam int ROW_W = $clog2(HEIGHT);

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(WIDTH - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(HEIGHT - 1);

	localparam int PIX_W = 8;

	typedef logic [PIX_W-1:0] pixel_t;

	// 3x3 neighborhood: [row][col], row 0 is the oldest line, col 0 the leftmost
	typedef pixel_t [2:0][2:0] window_t;

	typedef enum logic [2:0] {
		MODE_GRAY    = 3'd0,
		MODE_BW      = 3'd1,
		MODE_INVERT  = 3'd2,
		MODE_BLUR    = 3'd3,
		MODE_SHARPEN = 3'd4,
		MODE_SOBEL   = 3'd5
	} mode_t;

	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_DRAIN = 1'b1
	} func_t;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_THRESH = 1'b1;

	localparam logic [2:0] MODE_RESET   = 3'd0;
	localparam pixel_t     THRESH_RESET = 8'd128;

endpackage

/* hdl/rwf_if.sv */
interface rwf_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] pixel_in;

	modport source (output valid, output func, output pixel_in, input ready);
	modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface rwf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	logic [8:0] out_col;
	logic [7:0] out_row;
	logic       frame_done;
	logic       last_of_item;

	modport source (output valid, output pixel_out, output out_col, output out_row,
		output frame_done, output last_of_item, input ready);
	modport sink   (input valid, input pixel_out, input out_col, input out_row,
		input frame_done, input last_of_item, output ready);
endinterface

/* hdl/rwf_ram.sv */
module rwf_ram #(
	parameter int DW = 8,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/rwf_filter.sv */
module rwf_filter
	import rwf_pkg::*;
(
	input  window_t    win,
	input  logic [2:0] mode,
	input  pixel_t     threshold,
	output pixel_t     pixel
);

	function automatic logic [2:0] chan_of(pixel_t p, int ch);
		case (ch)
			0:       return p[7:5];
			1:       return {1'b0, p[4:3]};
			default: return {1'b0, p[2:1]};
		endcase
	endfunction

	logic [2:0] blur_r  [3];
	logic [2:0] sharp_r [3];
	logic [2:0] sobel_r [3];
	logic [4:0] gray_sum;
	logic [7:0] gray_prod;
	logic [2:0] gray_v;

	always_comb begin
		logic [2:0]        p [3][3];
		logic [5:0]        bsum;
		logic [11:0]       bprod;
		logic signed [6:0] sv;
		logic signed [6:0] gx;
		logic signed [6:0] gy;
		logic [5:0]        mag;
		logic [2:0]        hi;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p[i][j] = chan_of(win[i][j], ch);
				end
			end
			hi = (ch == 0) ? 3'd7 : 3'd3;

			// divide by 9 as multiply by 57/512, exact for sums up to 63
			bsum = 6'(p[0][0]) + 6'(p[0][1]) + 6'(p[0][2]) + 6'(p[1][0]) + 6'(p[1][1])
				+ 6'(p[1][2]) + 6'(p[2][0]) + 6'(p[2][1]) + 6'(p[2][2]);
			bprod = 12'(bsum) * 12'd57;
			blur_r[ch] = bprod[11:9];

			sv = 7'sd5 * $signed({4'd0, p[1][1]}) - $signed({4'd0, p[0][1]})
				- $signed({4'd0, p[2][1]}) - $signed({4'd0, p[1][0]})
				- $signed({4'd0, p[1][2]});
			if (sv < 0) begin
				sharp_r[ch] = 3'd0;
			end else if (sv > $signed({4'd0, hi})) begin
				sharp_r[ch] = hi;
			end else begin
				sharp_r[ch] = sv[2:0];
			end

			gx = $signed({4'd0, p[0][2]}) - $signed({4'd0, p[0][0]})
				+ 7'sd2 * ($signed({4'd0, p[1][2]}) - $signed({4'd0, p[1][0]}))
				+ $signed({4'd0, p[2][2]}) - $signed({4'd0, p[2][0]});
			gy = $signed({4'd0, p[2][0]}) - $signed({4'd0, p[0][0]})
				+ 7'sd2 * ($signed({4'd0, p[2][1]}) - $signed({4'd0, p[0][1]}))
				+ $signed({4'd0, p[2][2]}) - $signed({4'd0, p[0][2]});
			mag = 6'((gx < 0) ? -gx : gx) + 6'((gy < 0) ? -gy : gy);
			sobel_r[ch] = (mag[5:3] > hi) ? hi : mag[5:3];
		end
	end

	// divide by 3 as multiply by 11/32, exact for sums up to 19
	assign gray_sum  = 5'(win[1][1][7:5]) + {2'd0, win[1][1][4:3], 1'b0}
		+ {2'd0, win[1][1][2:1], 1'b0};
	assign gray_prod = 8'(gray_sum) * 8'd11;
	assign gray_v    = gray_prod[7:5];

	always_comb begin
		case (mode)
			MODE_GRAY:    pixel = {gray_v, gray_v[2:1], gray_v[2:1], 1'b0};
			MODE_BW:      pixel = (win[1][1] >= threshold) ? 8'hFF : 8'h00;
			MODE_INVERT:  pixel = ~win[1][1];
			MODE_BLUR:    pixel = {blur_r[0], blur_r[1][1:0], blur_r[2][1:0], 1'b0};
			MODE_SHARPEN: pixel = {sharp_r[0], sharp_r[1][1:0], sharp_r[2][1:0], 1'b0};
			MODE_SOBEL:   pixel = {sobel_r[0], sobel_r[1][1:0], sobel_r[2][1:0], 1'b0};
			default:      pixel = win[1][1];
		endcase
	end

endmodule

/* hdl/rgb_window_filter_3x3.sv */
// Channel | Dir | Payload
// src     | in  | func, pixel_in
// dst     | out | pixel_out, out_col, out_row, frame_done, last_of_item
// cfg     | in  | cfg_we, cfg_index, cfg_data (mode, threshold)
//
// One item is taken per cycle unless a stall on dst backs up through the result register
// to src.ready; the item at the last column gives two results, and input waits for both.
// The pipeline runs line-store read, window and result register.
// Reset clears counters, window and valid flags; line stores need no clearing.
module rgb_window_filter_3x3
	import rwf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	rwf_in_if.sink      src,
	rwf_out_if.source   dst
);

	logic [2:0]       mode_q;
	pixel_t           thresh_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] drain_cnt_q;
	logic             draining_q;

	logic             valid_s1;
	logic             drain_s1;
	pixel_t           pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             active_s1;
	logic             row_one_s1;
	logic [ROW_W-1:0] orow_s1;
	logic             last_row_s1;

	logic             valid_s2;
	logic             two_s2;
	logic             phase_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] orow_s2;
	logic             last_row_s2;
	pixel_t           v_s2 [3];

	window_t          win_q;

	logic             out_valid_q;
	pixel_t           out_pix_q;
	logic [8:0]       out_col_q;
	logic [7:0]       out_row_q;
	logic             out_done_q;
	logic             out_last_q;

	logic             in_acc;
	logic             take;
	logic             is_pixel;
	logic [COL_W-1:0] c_new;
	logic             s1_adv;
	logic             out_free;
	logic             s2_fire;
	logic             s2_final;
	logic             s2_first;
	logic [COL_W-1:0] rd_addr;
	pixel_t           a_rd;
	pixel_t           b_rd;
	pixel_t           v [3];
	pixel_t           filt_pix;

	assign is_pixel = (src.func == FUNC_PIXEL);
	assign in_acc   = src.valid && src.ready;
	// drain ticks with no row pending are accepted and dropped
	assign take     = in_acc && (is_pixel || draining_q);
	assign c_new    = is_pixel ? in_col_q : drain_cnt_q;

	assign out_free = !out_valid_q || dst.ready;
	assign s2_fire  = valid_s2 && out_free;
	assign s2_final = s2_fire && (!two_s2 || phase_s2);
	assign s2_first = s2_fire && two_s2 && !phase_s2;
	assign s1_adv   = valid_s1 && (!valid_s2 || s2_final);
	assign src.ready = !valid_s1 || s1_adv;

	// re-read the held column while stage 1 waits so the read data stays current
	assign rd_addr = in_acc ? c_new : col_s1;

	rwf_ram #(.DW(PIX_W), .DEPTH(WIDTH)) u_line_a (
		.clk   (clk),
		.we    (s1_adv && !drain_s1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.raddr (rd_addr),
		.rdata (a_rd)
	);

	rwf_ram #(.DW(PIX_W), .DEPTH(WIDTH)) u_line_b (
		.clk   (clk),
		.we    (s1_adv && !drain_s1),
		.waddr (col_s1),
		.wdata (a_rd),
		.raddr (rd_addr),
		.rdata (b_rd)
	);

	always_comb begin
		if (drain_s1) begin
			v[0] = b_rd;
			v[1] = a_rd;
			v[2] = a_rd;
		end else begin
			v[0] = row_one_s1 ? a_rd : b_rd;
			v[1] = a_rd;
			v[2] = pix_s1;
		end
	end

	rwf_filter u_filter (
		.win       (win_q),
		.mode      (mode_q),
		.threshold (thresh_q),
		.pixel     (filt_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[2:0];
				CFG_THRESH: thresh_q <= cfg_data;
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	// input position and drain tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			drain_cnt_q <= '0;
			draining_q  <= 1'b0;
		end else if (take) begin
			if (is_pixel) begin
				drain_cnt_q <= '0;
				draining_q  <= 1'b0;
				if (in_col_q == COL_LAST) begin
					in_col_q <= '0;
					if (in_row_q == ROW_LAST) begin
						in_row_q   <= '0;
						draining_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end else begin
				if (drain_cnt_q == COL_LAST) begin
					drain_cnt_q <= '0;
					draining_q  <= 1'b0;
				end else begin
					drain_cnt_q <= drain_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			drain_s1 <= !is_pixel;
			pix_s1   <= src.pixel_in;
			col_s1   <= c_new;
			if (is_pixel) begin
				active_s1   <= (in_row_q != '0);
				row_one_s1  <= (in_row_q == ROW_W'(1));
				orow_s1     <= in_row_q - 1'b1;
				last_row_s1 <= 1'b0;
			end else begin
				active_s1   <= 1'b1;
				row_one_s1  <= 1'b0;
				orow_s1     <= ROW_LAST;
				last_row_s1 <= 1'b1;
			end
		end
	end

	// window: fill on column 0, shift on every other column and on the extra edge step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			for (int k = 0; k < 3; k++) begin
				if (col_s1 == '0) begin
					win_q[k][0] <= v[k];
					win_q[k][1] <= v[k];
				end else begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
				end
				win_q[k][2] <= v[k];
			end
		end else if (s2_first) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
				win_q[k][2] <= v_s2[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= active_s1 && (col_s1 != '0);
			phase_s2 <= 1'b0;
		end else if (s2_first) begin
			phase_s2 <= 1'b1;
		end else if (s2_final) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			two_s2      <= (col_s1 == COL_LAST);
			col_s2      <= col_s1;
			orow_s2     <= orow_s1;
			last_row_s2 <= last_row_s1;
			for (int k = 0; k < 3; k++) begin
				v_s2[k] <= v[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_fire) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			out_pix_q  <= filt_pix;
			out_col_q  <= phase_s2 ? 9'(col_s2) : 9'(col_s2 - 1'b1);
			out_row_q  <= 8'(orow_s2);
			out_last_q <= !two_s2 || phase_s2;
			out_done_q <= phase_s2 && last_row_s2;
		end
	end

	assign dst.valid        = out_valid_q;
	assign dst.pixel_out    = out_pix_q;
	assign dst.out_col      = out_col_q;
	assign dst.out_row      = out_row_q;
	assign dst.frame_done   = out_done_q;
	assign dst.last_of_item = out_last_q;

endmodule

/* sim/rwf_checker.sv */
module rwf_checker
	import rwf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	rwf_in_if          src,
	rwf_out_if         dst,
	output int         errors,
	output int         pending,
	output int         results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		pixel_t     pix;
		logic [8:0] col;
		logic [7:0] row;
		logic       done;
		logic       last;
	} filtered_px_t;

	filtered_px_t expected_px[$];

	pixel_t     rows_mem[2*WIDTH];
	pixel_t     win[3][3];
	int         col_pos, row_pos, flush_pos;
	logic       flushing;
	logic [2:0] cur_mode;
	pixel_t     cur_thr;

	assign pending = expected_px.size();

	function automatic int chan(pixel_t p, int ch);
		if (ch == 0) return int'(p[7:5]);
		if (ch == 1) return int'(p[4:3]);
		return int'(p[2:1]);
	endfunction

	function automatic pixel_t pack(int r, int g, int b);
		pixel_t p;
		p = '0;
		p[7:5] = r[2:0];
		p[4:3] = g[1:0];
		p[2:1] = b[1:0];
		return p;
	endfunction

	function automatic int clip(int v, int hi);
		return v < 0 ? 0 : (v > hi ? hi : v);
	endfunction

	function automatic int mag(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic pixel_t filtered();
		int res[3];
		int hi[3];
		int s, g, gx, gy;
		pixel_t c;
		hi = '{7, 3, 3};
		c = win[1][1];
		case (cur_mode)
			MODE_GRAY: begin
				g = (chan(c, 0) + 2*chan(c, 1) + 2*chan(c, 2)) / 3;
				if (g > 7) g = 7;
				return pack(g, g >> 1, g >> 1);
			end
			MODE_BW: return (c >= cur_thr) ? 8'hFF : 8'h00;
			MODE_INVERT: return 8'hFF - c;
			MODE_BLUR: begin
				for (int ch = 0; ch < 3; ch++) begin
					s = 0;
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++) s += chan(win[i][j], ch);
					res[ch] = s / 9;
				end
				return pack(res[0], res[1], res[2]);
			end
			MODE_SHARPEN: begin
				for (int ch = 0; ch < 3; ch++)
					res[ch] = clip(5*chan(c, ch) - chan(win[0][1], ch) - chan(win[2][1], ch)
						- chan(win[1][0], ch) - chan(win[1][2], ch), hi[ch]);
				return pack(res[0], res[1], res[2]);
			end
			MODE_SOBEL: begin
				for (int ch = 0; ch < 3; ch++) begin
					gx = -chan(win[0][0], ch) + chan(win[0][2], ch) - 2*chan(win[1][0], ch)
						+ 2*chan(win[1][2], ch) - chan(win[2][0], ch) + chan(win[2][2], ch);
					gy = -chan(win[0][0], ch) - 2*chan(win[0][1], ch) - chan(win[0][2], ch)
						+ chan(win[2][0], ch) + 2*chan(win[2][1], ch) + chan(win[2][2], ch);
					res[ch] = clip((mag(gx) + mag(gy)) / 8, hi[ch]);
				end
				return pack(res[0], res[1], res[2]);
			end
			default: return c;
		endcase
	endfunction

	function automatic void shift_col(pixel_t v[3]);
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
			win[k][2] = v[k];
		end
	endfunction

	function automatic void add_px(int c, int r, logic done);
		filtered_px_t e;
		e.pix  = filtered();
		e.col  = c[8:0];
		e.row  = r[7:0];
		e.done = done;
		e.last = 1'b0;
		expected_px.push_back(e);
	endfunction

	// push the results of one window column; tag the last of them
	function automatic void feed_col(int c, pixel_t v[3], logic active, int orow, logic last_row);
		int n;
		filtered_px_t e;
		n = 0;
		if (c == 0) begin
			shift_col(v); shift_col(v); shift_col(v);
		end else begin
			shift_col(v);
		end
		if (!active) return;
		if (c >= 1) begin
			add_px(c - 1, orow, 1'b0);
			n++;
		end
		if (c == WIDTH - 1) begin
			shift_col(v);
			add_px(c, orow, last_row);
			n++;
		end
		if (n > 0) begin
			e = expected_px.pop_back();
			e.last = 1'b1;
			expected_px.push_back(e);
		end
	endfunction

	function automatic void take_item(logic f, pixel_t pix);
		pixel_t v[3];
		if (f == FUNC_PIXEL) begin
			flushing = 1'b0;
			flush_pos = 0;
			v[0] = (row_pos == 1) ? rows_mem[col_pos] : rows_mem[WIDTH + col_pos];
			v[1] = rows_mem[col_pos];
			v[2] = pix;
			rows_mem[WIDTH + col_pos] = rows_mem[col_pos];
			rows_mem[col_pos] = pix;
			feed_col(col_pos, v, row_pos >= 1, row_pos - 1, 1'b0);
			if (++col_pos >= WIDTH) begin
				col_pos = 0;
				if (++row_pos >= HEIGHT) begin
					row_pos = 0;
					flushing = 1'b1;
				end
			end
		end else if (flushing) begin
			v[0] = rows_mem[WIDTH + flush_pos];
			v[1] = rows_mem[flush_pos];
			v[2] = rows_mem[flush_pos];
			feed_col(flush_pos, v, 1'b1, HEIGHT - 1, 1'b1);
			if (++flush_pos >= WIDTH) begin
				flush_pos = 0;
				flushing = 1'b0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_px_t e;
		if (!arst_n) begin
			for (int i = 0; i < 2*WIDTH; i++) rows_mem[i] = '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win[i][j] = '0;
			col_pos = 0; row_pos = 0; flush_pos = 0;
			flushing = 1'b0;
			cur_mode = MODE_RESET;
			cur_thr = THRESH_RESET;
			expected_px.delete();
			errors = 0;
			results = 0;
		end else begin
			if (dst.valid && dst.ready) begin
				results++;
				if (expected_px.size() == 0) begin
					$error("unexpected result transfer: pixel %0h col %0d row %0d",
						dst.pixel_out, dst.out_col, dst.out_row);
					errors++;
				end else begin
					e = expected_px.pop_front();
					if (dst.pixel_out !== e.pix) begin
						$error("pixel_out: expected %0h, got %0h", e.pix, dst.pixel_out);
						errors++;
					end
					if (dst.out_col !== e.col) begin
						$error("out_col: expected %0d, got %0d", e.col, dst.out_col);
						errors++;
					end
					if (dst.out_row !== e.row) begin
						$error("out_row: expected %0d, got %0d", e.row, dst.out_row);
						errors++;
					end
					if (dst.frame_done !== e.done) begin
						$error("frame_done: expected %0b, got %0b", e.done, dst.frame_done);
						errors++;
					end
					if (dst.last_of_item !== e.last) begin
						$error("last_of_item: expected %0b, got %0b", e.last, dst.last_of_item);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_MODE) cur_mode = cfg_data[2:0];
				else cur_thr = cfg_data;
			end
			if (src.valid && src.ready) take_item(src.func, src.pixel_in);
		end
	end

endmodule

/* sim/rgb_window_filter_3x3_tb.sv */
module rgb_window_filter_3x3_tb;
	import rwf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	int         errors, pending, results;
	int         burst_left;
	int         n_pixels, n_ticks, n_cfg;

	rwf_in_if  src ();
	rwf_out_if dst ();

	rgb_window_filter_3x3 dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.src(src), .dst(dst)
	);

	rwf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.src(src), .dst(dst),
		.errors(errors), .pending(pending), .results(results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("rgb_window_filter_3x3_tb failed");
		$finish;
	end

	// sink side: the stall density is redrawn at random, with a long hold-off now and then
	initial begin
		int cyc;
		int dens;
		int hold;
		cyc = 0; dens = 0; hold = 0;
		dst.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 256 == 0) dens = $urandom_range(0, 3);
			if (cyc % 1500 == 900) hold = 300;
			if (hold > 0) begin
				hold--;
				dst.ready <= 1'b0;
			end else begin
				case (dens)
					0: dst.ready <= 1'b1;
					1: dst.ready <= ($urandom_range(0, 3) != 0);
					2: dst.ready <= $urandom_range(0, 1);
					default: dst.ready <= (cyc % 8 != 0);
				endcase
			end
		end
	end

	task automatic send(input func_t f, input pixel_t p);
		int gap;
		logic rdy;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				src.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		src.valid    <= 1'b1;
		src.func     <= f;
		src.pixel_in <= p;
		// ready is stable by the falling edge; the next rising edge is the transfer
		do begin
			@(negedge clk);
			rdy = src.ready;
			@(posedge clk);
		end while (!rdy);
		if (f == FUNC_PIXEL) n_pixels++;
		else n_ticks++;
	endtask

	// hold the input, let everything drain, then write one register
	task automatic write_reg(input logic idx, input logic [7:0] val);
		src.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	function automatic pixel_t pick_pixel();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return {7'h7F, 1'($urandom_range(0, 1))};
			default: return pixel_t'($urandom_range(0, 255));
		endcase
	endfunction

	// new mode every 40 columns, shifted from row to row so different modes meet the borders
	task automatic run_rows(input int nrows);
		pixel_t edge_px[12];
		int seg;
		edge_px = '{8'h00, 8'hFF, 8'hFE, 8'h01, 8'hE0, 8'h18, 8'h06, 8'h80,
			8'h7F, 8'h00, 8'hFF, 8'h00};
		for (int r = 0; r < nrows; r++) begin
			for (int c = 0; c < WIDTH; c++) begin
				if (c % 40 == 0) begin
					seg = c / 40 + r;
					write_reg(CFG_MODE, 8'((c / 40 + 3 * r) % 8));
					case (seg % 3)
						0: write_reg(CFG_THRESH, 8'h00);
						1: write_reg(CFG_THRESH, 8'hFF);
						default: write_reg(CFG_THRESH, 8'($urandom_range(1, 254)));
					endcase
				end
				send(FUNC_PIXEL, (r == 0 && c < 12) ? edge_px[c] : pick_pixel());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = CFG_MODE; cfg_data = '0;
		src.valid = 1'b0; src.func = FUNC_PIXEL; src.pixel_in = '0;
		burst_left = 0;
		n_pixels = 0; n_ticks = 0; n_cfg = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drain ticks with nothing pending are dropped
		repeat (3) send(FUNC_DRAIN, pick_pixel());

		// first rows of a frame, then stray drain ticks at the end
		run_rows(4);
		for (int c = 0; c < 100; c++) send(FUNC_DRAIN, pick_pixel());

		src.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d pixels over the top rows of a frame, %0d idle drain ticks, %0d register writes",
			n_pixels, n_ticks, n_cfg);
		$display("%0d results checked in every mode, including right-edge double results",
			results);
		if (errors == 0) begin
			$display("rgb_window_filter_3x3_tb passed");
		end else begin
			$display("rgb_window_filter_3x3_tb failed");
		end
		$finish;
	end

endmodule
